// ===== hw/rtl/pess_pkg.sv =====
// shared types and constants of the priority evicting state store
// no dependencies; used by pess_ctrl, pess_dp and the top level
package pess_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ID_W            = 16;
  localparam int LEN_W           = 16;
  localparam int PRIO_W          = 16;
  localparam int SIZE_W          = 18;
  localparam int COST_W          = LEN_W + 1;
  localparam int OUT_CNT_W       = 5;
  localparam int ENT_W           = ID_W + LEN_W + PRIO_W;

  localparam logic [COST_W-1:0] ENTRY_OVERHEAD = COST_W'(64);
  localparam logic [SIZE_W-1:0] MEM_SIZE_RST   = SIZE_W'(4096);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    RES_ADDED     = 3'd0,
    RES_DUP       = 3'd1,
    RES_REMOVED   = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_TOO_LARGE = 3'd4,
    RES_EVICT     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DROP,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    scan_clr;
    logic    scan_step;
    logic    drop;
    logic    shift_step;
    logic    append;
    logic    emit;
    status_t status;
    logic    last;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic too_large;
    logic need_evict;
    logic req_remove;
    logic shift_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/priority_evicting_state_store_top.sv =====
// top level of the priority evicting state store
// depends on pess_pkg, pess_ctrl and pess_dp
//
// A request is taken when start is high and busy is low. Results appear on out_* for one
// cycle each, marked by out_strobe, and cannot be held off; out_last marks the final one of
// a request. After the accepting edge the table scan reads each held entry in turn, and
// each result is registered and shows in the cycle after the step that makes it. Each
// eviction or removal drops the victim, then moves any later entries down by one slot; an
// add scans the table again after each eviction. The scan and the compaction read the
// entries through the single read port of the entry memory. For an add busy falls in the
// cycle that carries the final result; for a removal it stays high until the compaction
// ends. memory_size may be written on cfg_* while the block is idle.
module priority_evicting_state_store_top import pess_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [ID_W-1:0]      in_item_id,
  input  logic [LEN_W-1:0]     in_item_length,
  input  logic [PRIO_W-1:0]    in_priority_req,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SIZE_W-1:0]    cfg_memory_size,
  output logic                 out_strobe,
  output logic [2:0]           out_status,
  output logic                 out_reclaimed_valid,
  output logic [ID_W-1:0]      out_reclaimed_id,
  output logic [SIZE_W-1:0]    out_memory_used,
  output logic [OUT_CNT_W-1:0] out_entry_count,
  output logic                 out_last
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  pess_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pess_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .req_command         (in_command),
    .req_item_id         (in_item_id),
    .req_item_length     (in_item_length),
    .req_priority_req    (in_priority_req),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_memory_size     (cfg_memory_size),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_reclaimed_valid (out_reclaimed_valid),
    .out_reclaimed_id    (out_reclaimed_id),
    .out_memory_used     (out_memory_used),
    .out_entry_count     (out_entry_count),
    .out_last            (out_last)
  );

endmodule

// ===== hw/rtl/pess_dp.sv =====
// datapath: entry memory, scan and compaction logic, occupancy and result registers
// depends on pess_pkg; driven by pess_ctrl through ctl_cmd_t
module pess_dp import pess_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_cmd_t             cmd,
  output dp_sts_t              sts,
  input  logic                 req_command,
  input  logic [ID_W-1:0]      req_item_id,
  input  logic [LEN_W-1:0]     req_item_length,
  input  logic [PRIO_W-1:0]    req_priority_req,
  input  logic                 cfg_we,
  input  logic [SIZE_W-1:0]    cfg_memory_size,
  output logic                 out_strobe,
  output logic [2:0]           out_status,
  output logic                 out_reclaimed_valid,
  output logic [ID_W-1:0]      out_reclaimed_id,
  output logic [SIZE_W-1:0]    out_memory_used,
  output logic [OUT_CNT_W-1:0] out_entry_count,
  output logic                 out_last
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  logic [ENT_W-1:0]  mem_r [MAX_ENTRIES];
  logic [ENT_W-1:0]  rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;

  logic [SIZE_W-1:0] mem_size_r;
  logic [SIZE_W-1:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              req_cmd_r;
  logic [ID_W-1:0]   req_id_r;
  logic [LEN_W-1:0]  req_len_r;
  logic [PRIO_W-1:0] req_prio_r;

  logic [CNT_W-1:0]  scan_idx_r;
  logic              scan_pend_r;
  logic [IDX_W-1:0]  scan_pidx_r;
  logic              found_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [LEN_W-1:0]  match_len_r;
  logic              best_v_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [PRIO_W-1:0] best_prio_r;
  logic [LEN_W-1:0]  best_len_r;
  logic [ID_W-1:0]   best_id_r;

  logic [CNT_W-1:0]  sh_rd_r;
  logic              sw_v_r;
  logic [IDX_W-1:0]  sw_addr_r;

  logic              out_strobe_r;
  status_t           out_status_r;
  logic              out_rv_r;
  logic [ID_W-1:0]   out_rid_r;
  logic [SIZE_W-1:0] out_used_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r;

  logic [ID_W-1:0]   rd_id;
  logic [LEN_W-1:0]  rd_len;
  logic [PRIO_W-1:0] rd_prio;
  logic              scan_rd_ok;
  logic              shift_rd_ok;
  logic [COST_W-1:0] new_cost;
  logic [COST_W-1:0] victim_cost;
  logic [IDX_W-1:0]  victim_idx;
  logic [ID_W-1:0]   victim_id;
  logic [SIZE_W:0]   need_sum;

  assign rd_id   = rd_data_r[ENT_W-1 -: ID_W];
  assign rd_len  = rd_data_r[PRIO_W +: LEN_W];
  assign rd_prio = rd_data_r[PRIO_W-1:0];

  assign scan_rd_ok  = cmd.scan_step && (scan_idx_r < count_r);
  assign shift_rd_ok = cmd.shift_step && (sh_rd_r <= count_r);
  assign rd_en       = scan_rd_ok || shift_rd_ok;
  assign rd_addr     = cmd.shift_step ? sh_rd_r[IDX_W-1:0] : scan_idx_r[IDX_W-1:0];

  assign wr_en   = cmd.append || sw_v_r;
  assign wr_addr = cmd.append ? count_r[IDX_W-1:0] : sw_addr_r;
  assign wr_data = cmd.append ? {req_id_r, req_len_r, req_prio_r} : rd_data_r;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign new_cost    = {1'b0, req_len_r} + ENTRY_OVERHEAD;
  assign victim_idx  = req_cmd_r ? match_idx_r : best_idx_r;
  assign victim_id   = req_cmd_r ? req_id_r : best_id_r;
  assign victim_cost = {1'b0, (req_cmd_r ? match_len_r : best_len_r)} + ENTRY_OVERHEAD;
  assign need_sum    = {1'b0, bytes_r} + (SIZE_W + 1)'(new_cost);

  always_comb begin
    bytes_nxt = bytes_r;
    count_nxt = count_r;
    if (cmd.drop) begin
      bytes_nxt = (bytes_r >= SIZE_W'(victim_cost)) ? bytes_r - SIZE_W'(victim_cost) : '0;
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.append) begin
      bytes_nxt = bytes_r + SIZE_W'(new_cost);
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= MEM_SIZE_RST;
      bytes_r    <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_we) begin
        mem_size_r <= cfg_memory_size;
      end
      bytes_r <= bytes_nxt;
      count_r <= count_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r  <= req_command;
      req_id_r   <= req_item_id;
      req_len_r  <= req_item_length;
      req_prio_r <= req_priority_req;
    end
  end

  // table scan: id match and oldest lowest priority in one pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      scan_pend_r <= 1'b0;
      found_r     <= 1'b0;
      best_v_r    <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_idx_r  <= '0;
      scan_pend_r <= 1'b0;
      found_r     <= 1'b0;
      best_v_r    <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        scan_pend_r <= scan_rd_ok;
        if (scan_rd_ok) begin
          scan_idx_r  <= scan_idx_r + CNT_W'(1);
          scan_pidx_r <= scan_idx_r[IDX_W-1:0];
        end
      end
      if (scan_pend_r) begin
        if (!found_r && rd_id == req_id_r) begin
          found_r     <= 1'b1;
          match_idx_r <= scan_pidx_r;
          match_len_r <= rd_len;
        end
        if (!best_v_r || rd_prio < best_prio_r) begin
          best_v_r    <= 1'b1;
          best_idx_r  <= scan_pidx_r;
          best_prio_r <= rd_prio;
          best_len_r  <= rd_len;
          best_id_r   <= rd_id;
        end
      end
    end
  end

  // compaction: move each later entry down by one slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_v_r <= 1'b0;
    end else if (cmd.drop) begin
      sh_rd_r <= CNT_W'(victim_idx) + CNT_W'(1);
      sw_v_r  <= 1'b0;
    end else if (cmd.shift_step) begin
      sw_v_r <= shift_rd_ok;
      if (shift_rd_ok) begin
        sh_rd_r   <= sh_rd_r + CNT_W'(1);
        sw_addr_r <= IDX_W'(sh_rd_r - CNT_W'(1));
      end
    end else begin
      sw_v_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_rv_r     <= cmd.drop;
      out_rid_r    <= cmd.drop ? victim_id : '0;
      out_used_r   <= bytes_nxt;
      out_cnt_r    <= count_nxt;
      out_last_r   <= cmd.last;
    end
  end

  assign sts.scan_done  = (scan_idx_r >= count_r) && !scan_pend_r;
  assign sts.found      = found_r;
  assign sts.too_large  = {1'b0, new_cost} > mem_size_r;
  assign sts.need_evict = (count_r != '0) &&
                          ((need_sum > {1'b0, mem_size_r}) || (count_r >= CNT_MAX));
  assign sts.req_remove = (req_cmd_r == CMD_REMOVE);
  assign sts.shift_done = (sh_rd_r > count_r) && !sw_v_r;

  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_reclaimed_valid = out_rv_r;
  assign out_reclaimed_id    = out_rid_r;
  assign out_memory_used     = out_used_r;
  assign out_entry_count     = OUT_CNT_W'(out_cnt_r);
  assign out_last            = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("entry count beyond table depth");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (count_r < CNT_MAX) && !sw_v_r)
    else $error("append into full table or during compaction");

  a_reclaim_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_rv_r) |-> (out_status_r == RES_REMOVED || out_status_r == RES_EVICT))
    else $error("reclaimed id on a result that releases nothing");

endmodule

// ===== hw/rtl/pess_ctrl.sv =====
// controller: sequences scan, eviction, compaction and result emission
// depends on pess_pkg; drives pess_dp through ctl_cmd_t
module pess_ctrl import pess_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          priority if (sts.req_remove && sts.found) begin
            state_nxt = S_DROP;
          end else if (sts.req_remove) begin
            cmd.emit   = 1'b1;
            cmd.status = RES_NOT_FOUND;
            cmd.last   = 1'b1;
            state_nxt  = S_IDLE;
          end else if (sts.found) begin
            cmd.emit   = 1'b1;
            cmd.status = RES_DUP;
            cmd.last   = 1'b1;
            state_nxt  = S_IDLE;
          end else if (sts.too_large) begin
            cmd.emit   = 1'b1;
            cmd.status = RES_TOO_LARGE;
            cmd.last   = 1'b1;
            state_nxt  = S_IDLE;
          end else if (sts.need_evict) begin
            state_nxt = S_DROP;
          end else begin
            cmd.append = 1'b1;
            cmd.emit   = 1'b1;
            cmd.status = RES_ADDED;
            cmd.last   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_DROP: begin
        cmd.drop   = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = sts.req_remove ? RES_REMOVED : RES_EVICT;
        cmd.last   = sts.req_remove;
        state_nxt  = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) begin
          if (sts.req_remove) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_drop_then_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DROP) |=> (state_r == S_SHIFT))
    else $error("drop not followed by compaction");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_SCAN))
    else $error("accepted request did not start a scan");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE || state_r == S_SHIFT))
    else $error("work continues after final result");

endmodule
